// ----- hw/rtl/lpc_predictor_restore_assert.svh -----
// Assertion macros for the LPC predictor restore block.
// Expects clk and rst_n in scope at the point of use.
`ifndef LPC_PREDICTOR_RESTORE_ASSERT_SVH
`define LPC_PREDICTOR_RESTORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LPCR_ASSERT_IMPL(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lpc_predictor_restore: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define LPCR_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lpc_predictor_restore: next-cycle check failed");

`endif

// ----- hw/rtl/lpcr_pkg.sv -----
// Shared constants, types and the fixed-predictor coefficient table
// for the LPC predictor restore block. No dependencies.
package lpcr_pkg;

    localparam int MAX_ORDER  = 32;
    localparam int HIST_DEPTH = 32;
    localparam int COEF_DEPTH = 32;
    localparam int TAP_W      = 5;
    localparam int SAMPLE_W   = 33;
    localparam int COEF_W     = 15;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 54;
    localparam int PRED_W     = 70;
    localparam int SUM_W      = 65;
    localparam int ORDER_W    = 6;

    localparam logic signed [PRED_W-1:0] PRED_LIMIT   = 70'sh0_4000_0000_0000_0000;
    localparam logic signed [PRED_W-1:0] PRED_LIMIT_N = -PRED_LIMIT;

    // input item kinds
    localparam logic [1:0] KIND_COEF  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_ORDER = 2'd1;
    localparam logic [1:0] CFG_SHIFT = 2'd2;
    localparam logic [1:0] CFG_BITS  = 2'd3;

    typedef struct packed {
        logic             clear;
        logic             issue;
        logic             use_fixed;
        logic [2:0]       fixed_order;
        logic [TAP_W-1:0] tap;
    } mac_ctrl_t;

    // Binomial predictor weights, tap 0 is the most recent sample.
    function automatic logic signed [COEF_W-1:0] fixed_coef(input logic [2:0] order,
                                                            input logic [TAP_W-1:0] tap);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (order)
            3'd1: c = (tap == 5'd0) ? 15'sd1 : 15'sd0;
            3'd2:
            begin
                case (tap)
                    5'd0:    c = 15'sd2;
                    5'd1:    c = -15'sd1;
                    default: c = 15'sd0;
                endcase
            end
            3'd3:
            begin
                case (tap)
                    5'd0:    c = 15'sd3;
                    5'd1:    c = -15'sd3;
                    5'd2:    c = 15'sd1;
                    default: c = 15'sd0;
                endcase
            end
            3'd4:
            begin
                case (tap)
                    5'd0:    c = 15'sd4;
                    5'd1:    c = -15'sd6;
                    5'd2:    c = 15'sd4;
                    5'd3:    c = -15'sd1;
                    default: c = 15'sd0;
                endcase
            end
            default: c = 15'sd0;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/lpcr_mac.sv -----
// Coefficient store and shared multiply-accumulate pipeline:
// read stage, product register, accumulator. Uses lpcr_pkg.
module lpcr_mac
    import lpcr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     coef_we,
    input  logic [TAP_W-1:0]         coef_waddr,
    input  logic [COEF_W-1:0]        coef_wdata,
    input  mac_ctrl_t                ctrl,
    input  logic signed [SAMPLE_W-1:0] hist_in,
    output logic signed [ACC_W-1:0]  acc
);

    logic [COEF_W-1:0]          coef_mem [COEF_DEPTH];
    logic signed [COEF_W-1:0]   mem_q_reg;
    logic signed [COEF_W-1:0]   fix_q_reg;
    logic                       use_fixed_reg;
    logic signed [SAMPLE_W-1:0] hist_q_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       va_reg;
    logic                       vb_reg;
    logic signed [COEF_W-1:0]   coef_sel;

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        mem_q_reg <= coef_mem[ctrl.tap];
    end

    always_ff @(posedge clk)
    begin
        fix_q_reg     <= fixed_coef(ctrl.fixed_order, ctrl.tap);
        use_fixed_reg <= ctrl.use_fixed;
        hist_q_reg    <= hist_in;
    end

    assign coef_sel = use_fixed_reg ? fix_q_reg : mem_q_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= coef_sel * hist_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            va_reg <= ctrl.issue;
            vb_reg <= va_reg;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (vb_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc = acc_reg;

endmodule

// ----- hw/rtl/lpc_predictor_restore.sv -----
// Sequencing: load and block-start transactions complete in the idle state. A warm-up sample, or a
// fixed-mode sample past order 4, goes straight to the output state; a predicted sample runs one
// pass per tap through the single multiply-accumulate unit, then the shift, add and output states,
// where the tap count is the order in LPC mode (capped at 32) and 0..4 in fixed mode. A new item is
// accepted only in the idle state, after the last result is committed, which a stalled output delays.
// Reset (rst_n, async low) clears history, warm-up count, error flag, config, state and valid registers.
module lpc_predictor_restore
    import lpcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] coef_index, [37:5] value, [39:38] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [32:0] sample_out, [39:33] zero
    output logic        m_tuser,   // [0] range_error
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata
);

    `include "lpc_predictor_restore_assert.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic                       mode_reg;
    logic [ORDER_W-1:0]         order_reg;
    logic signed [4:0]          qs_reg;
    logic [ORDER_W-1:0]         sb_reg;
    logic signed [SAMPLE_W-1:0] history_reg [HIST_DEPTH];
    logic [ORDER_W-1:0]         warmup_reg;
    logic                       sticky_reg;
    logic [ORDER_W-1:0]         n_reg;
    logic [ORDER_W-1:0]         cnt_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SUM_W-1:0]    pred_reg;
    logic                       fail_reg;
    logic [SAMPLE_W-1:0]        result_reg;
    logic                       m_tvalid_reg;
    logic [SAMPLE_W-1:0]        m_data_reg;
    logic                       m_err_reg;

    logic                       in_acc;
    logic [1:0]                 kind;
    logic [TAP_W-1:0]           coef_index;
    logic signed [SAMPLE_W-1:0] value;
    logic [ORDER_W-1:0]         eff_order;
    logic                       out_free;
    logic                       commit;
    mac_ctrl_t                  mac_ctrl;
    logic signed [ACC_W-1:0]    acc;
    logic signed [PRED_W-1:0]   acc_ext;
    logic signed [PRED_W-1:0]   pred;
    logic [4:0]                 lshift;
    logic                       pred_bad;
    logic [ORDER_W-1:0]         bits_c;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    hi;
    logic signed [SUM_W-1:0]    lo;
    logic                       range_ok;
    logic [SAMPLE_W-1:0]        commit_val;

    assign kind       = s_tuser;
    assign coef_index = s_tdata[4:0];
    assign value      = s_tdata[37:5];
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign eff_order  = (order_reg > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign commit     = (state_reg == ST_OUT) && out_free;
    assign commit_val = fail_reg ? '0 : result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            order_reg <= '0;
            qs_reg    <= '0;
            sb_reg    <= 6'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MODE:  mode_reg  <= cfg_wdata[0];
                CFG_ORDER: order_reg <= cfg_wdata;
                CFG_SHIFT: qs_reg    <= cfg_wdata[4:0];
                CFG_BITS:  sb_reg    <= cfg_wdata;
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // shared multiply-accumulate
    always_comb
    begin
        mac_ctrl             = '0;
        mac_ctrl.clear       = in_acc;
        mac_ctrl.issue       = (state_reg == ST_MAC) && (cnt_reg < n_reg);
        mac_ctrl.use_fixed   = !mode_reg;
        mac_ctrl.fixed_order = n_reg[2:0];
        mac_ctrl.tap         = cnt_reg[TAP_W-1:0];
    end

    lpcr_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_we    (in_acc && (kind == KIND_COEF)),
        .coef_waddr (coef_index),
        .coef_wdata (value[COEF_W-1:0]),
        .ctrl       (mac_ctrl),
        .hist_in    (history_reg[cnt_reg[TAP_W-1:0]]),
        .acc        (acc)
    );

    // quantization shift and prediction limit
    always_comb
    begin
        acc_ext = {{(PRED_W-ACC_W){acc[ACC_W-1]}}, acc};
        lshift  = ~qs_reg + 5'd1;
        if (!mode_reg)
        begin
            pred = acc_ext;
        end
        else if (!qs_reg[4])
        begin
            pred = acc_ext >>> qs_reg[3:0];
        end
        else
        begin
            pred = acc_ext <<< lshift;
        end
        pred_bad = (pred > PRED_LIMIT) || (pred < PRED_LIMIT_N);
    end

    // residual add and range check
    always_comb
    begin
        if (sb_reg < 6'd4)
        begin
            bits_c = 6'd4;
        end
        else if (sb_reg > 6'd33)
        begin
            bits_c = 6'd33;
        end
        else
        begin
            bits_c = sb_reg;
        end
        sum      = pred_reg + {{(SUM_W-SAMPLE_W){value_reg[SAMPLE_W-1]}}, value_reg};
        hi       = (SUM_W'(1) << (bits_c - 6'd1)) - SUM_W'(1);
        lo       = ~hi;
        range_ok = (sum <= hi) && (sum >= lo);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (kind == KIND_SAMPLE))
                begin
                    if (warmup_reg < eff_order)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (!mode_reg && (eff_order > 6'd4))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                if (cnt_reg == n_reg + 6'd1)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: state_next = ST_ADD;
            ST_ADD:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            warmup_reg <= '0;
            sticky_reg <= 1'b0;
            n_reg      <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc && (kind == KIND_START))
            begin
                warmup_reg <= '0;
                sticky_reg <= 1'b0;
            end
            if (in_acc && (kind == KIND_SAMPLE) && (warmup_reg < eff_order))
            begin
                warmup_reg <= warmup_reg + 6'd1;
            end
            if (in_acc)
            begin
                n_reg   <= eff_order;
                cnt_reg <= '0;
            end
            else if (state_reg == ST_MAC)
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
            if (commit)
            begin
                sticky_reg <= sticky_reg | fail_reg;
            end
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            value_reg  <= value;
            result_reg <= value;
            fail_reg   <= !mode_reg && (eff_order > 6'd4) && !(warmup_reg < eff_order);
        end
        else if (state_reg == ST_SHIFT)
        begin
            pred_reg <= pred[SUM_W-1:0];
            fail_reg <= pred_bad;
        end
        else if (state_reg == ST_ADD)
        begin
            result_reg <= sum[SAMPLE_W-1:0];
            fail_reg   <= fail_reg || !range_ok;
        end
    end

    // history shift line, entry 0 the most recent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                history_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            for (int i = HIST_DEPTH - 1; i > 0; i--)
            begin
                history_reg[i] <= history_reg[i-1];
            end
            history_reg[0] <= commit_val;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_data_reg <= commit_val;
            m_err_reg  <= sticky_reg | fail_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_data_reg};
    assign m_tuser  = m_err_reg;

    `LPCR_ASSERT_NEXT(a_fail_flagged, commit && fail_reg, m_tvalid && m_tuser && (m_tdata == 40'd0))
    `LPCR_ASSERT_IMPL(a_warmup_bound, 1'b1, warmup_reg <= ORDER_W'(MAX_ORDER))
    `LPCR_ASSERT_IMPL(a_mac_count, state_reg == ST_MAC, cnt_reg <= n_reg + 6'd1)

endmodule
